[rtl/core/force_torque_moving_average_top_assert.svh]
// Assertion macros for the force/torque moving average block.
// Each macro expands to one labelled concurrent assertion in simulation
// and to nothing in synthesis.
`ifndef FORCE_TORQUE_MOVING_AVERAGE_TOP_ASSERT_SVH
`define FORCE_TORQUE_MOVING_AVERAGE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define FTMA_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: invariant violated");
`define FTMA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle implication violated");
`define FTMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication violated");
`else
`define FTMA_ASSERT(label, clk, rst, cond)
`define FTMA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define FTMA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/ftma_pkg.sv]
package ftma_pkg;

   localparam int CHANNELS = 6;
   localparam int DATA_W   = 32;

   // Ring depth. The mean is formed with a shift, so this is a power of two.
   localparam int WINDOW    = 16;
   localparam int WIN_SHIFT = $clog2(WINDOW);
   localparam int ADDR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W     = DATA_W + WIN_SHIFT;

   localparam int THR_W      = 31;
   localparam int GATE_W     = DATA_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [THR_W-1:0]  THR_RESET = THR_W'(65536);
   localparam logic [DATA_W-1:0] SAT_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GATE_THRESHOLD = 3'd0,
      CSR_BIAS_FORCE_X   = 3'd1,
      CSR_BIAS_FORCE_Y   = 3'd2,
      CSR_BIAS_FORCE_Z   = 3'd3,
      CSR_BIAS_TORQUE_X  = 3'd4,
      CSR_BIAS_TORQUE_Y  = 3'd5,
      CSR_BIAS_TORQUE_Z  = 3'd6
   } csr_index_type;

   // Element 0 is force x, element 5 is torque z.
   typedef logic [CHANNELS-1:0][DATA_W-1:0] chan_vec_type;
   typedef logic [CHANNELS-1:0][SUM_W-1:0]  sum_vec_type;

   typedef struct packed {
      logic                     sample_valid;
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
      logic signed [DATA_W-1:0] force_z;
      logic signed [DATA_W-1:0] torque_x;
      logic signed [DATA_W-1:0] torque_y;
      logic signed [DATA_W-1:0] torque_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] avg_force_x;
      logic signed [DATA_W-1:0] avg_force_y;
      logic signed [DATA_W-1:0] avg_force_z;
      logic signed [DATA_W-1:0] avg_torque_x;
      logic signed [DATA_W-1:0] avg_torque_y;
      logic signed [DATA_W-1:0] avg_torque_z;
   } rsp_payload_type;

   // Magnitude of a two's complement value; the most negative value maps to 2^31.
   function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + 1'b1) : v;
   endfunction

   // a - b, clamped to the signed 32-bit range.
   function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] diff;
      diff = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      if (diff[DATA_W] != diff[DATA_W-1]) begin
         return diff[DATA_W] ? SAT_MIN : SAT_MAX;
      end
      return diff[DATA_W-1:0];
   endfunction

endpackage

[rtl/core/ftma_ram.sv]
module ftma_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read-first: a read and write to the same address return the old word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/force_torque_moving_average_top.sv]
// Six-axis force/torque moving average with a deadband gate.
// The request channel carries one sensor sample per beat (valid flag, three
// forces, three torques, Q16.16). The response channel returns one beat per
// request holding the windowed mean of each channel over the last WINDOW
// stored values. The csr port sets the gate threshold and the six biases;
// write it only while no request is in flight.
// A request passes the ring stage, the sum stage and the response register.
// Throughput: one beat per cycle unless rsp_stall backs up the pipeline.
// The rings live in one RAM with a registered read; each beat reads the slot
// it overwrites, and the running sums are corrected by new minus old in the
// cycle the write goes back. Three holding stages (ring update, sum, response
// register) let requests keep flowing while a response waits; once all three
// are full under response stall, req_stall rises in the same cycle.
// Reset clears the pipeline, the running sums, the write pointer and the
// per-slot valid bits, so unwritten slots read as zero with no clearing
// pass; the threshold returns to 1.0 and the biases to zero.
`include "force_torque_moving_average_top_assert.svh"

module force_torque_moving_average_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  ftma_pkg::req_payload_type              req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output ftma_pkg::rsp_payload_type              rsp_payload,
   input  logic                                   csr_we,
   input  logic [ftma_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ftma_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // Configuration registers
   logic [ftma_pkg::THR_W-1:0] thr_ff;
   ftma_pkg::chan_vec_type     bias_ff;

   // Flow control
   logic req_take;
   logic a_adv;
   logic a_free;
   logic b_adv;
   logic b_free;

   // Input side
   ftma_pkg::chan_vec_type      raw;
   logic [ftma_pkg::GATE_W-1:0] gate_sum;
   logic                        gate_open;
   ftma_pkg::chan_vec_type      val_in;

   // Ring stage
   logic                        a_vld_ff;
   logic [ftma_pkg::ADDR_W-1:0] a_addr_ff;
   ftma_pkg::chan_vec_type      a_val_ff;
   logic                        a_old_ok_ff;
   logic                        a_fwd_ff;
   ftma_pkg::chan_vec_type      a_fwd_data_ff;
   logic                        fwd_hit;
   ftma_pkg::chan_vec_type      ram_rdata;
   ftma_pkg::chan_vec_type      old_val;

   logic [ftma_pkg::ADDR_W-1:0] wp_ff;
   logic [ftma_pkg::ADDR_W-1:0] wp_in;
   logic [ftma_pkg::WINDOW-1:0] ent_vld_ff;

   // Sum stage and response
   ftma_pkg::sum_vec_type       acc_ff;
   ftma_pkg::sum_vec_type       acc_in;
   logic                        b_vld_ff;
   ftma_pkg::chan_vec_type      mean_in;
   logic                        rsp_valid_ff;
   ftma_pkg::rsp_payload_type   rsp_payload_ff;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= ftma_pkg::THR_RESET;
         bias_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ftma_pkg::CSR_GATE_THRESHOLD: thr_ff     <= csr_wdata[ftma_pkg::THR_W-1:0];
            ftma_pkg::CSR_BIAS_FORCE_X:   bias_ff[0] <= csr_wdata;
            ftma_pkg::CSR_BIAS_FORCE_Y:   bias_ff[1] <= csr_wdata;
            ftma_pkg::CSR_BIAS_FORCE_Z:   bias_ff[2] <= csr_wdata;
            ftma_pkg::CSR_BIAS_TORQUE_X:  bias_ff[3] <= csr_wdata;
            ftma_pkg::CSR_BIAS_TORQUE_Y:  bias_ff[4] <= csr_wdata;
            ftma_pkg::CSR_BIAS_TORQUE_Z:  bias_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------- flow control
   assign b_adv    = b_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign b_free   = !b_vld_ff || b_adv;
   assign a_adv    = a_vld_ff && b_free;
   assign a_free   = !a_vld_ff || a_adv;
   assign req_stall = !a_free;
   assign req_take = req_valid && a_free;

   // ------------------------------------------------ gate and bias removal
   assign raw = {req_payload.torque_z, req_payload.torque_y, req_payload.torque_x,
                 req_payload.force_z, req_payload.force_y, req_payload.force_x};

   assign gate_sum = ftma_pkg::GATE_W'(ftma_pkg::magnitude(raw[0]))
                   + ftma_pkg::GATE_W'(ftma_pkg::magnitude(raw[1]))
                   + ftma_pkg::GATE_W'(ftma_pkg::magnitude(raw[2]));
   assign gate_open = req_payload.sample_valid
                   && (gate_sum > ftma_pkg::GATE_W'(thr_ff));

   always_comb begin
      for (int c = 0; c < ftma_pkg::CHANNELS; c++) begin
         val_in[c] = gate_open ? ftma_pkg::sat_sub(raw[c], bias_ff[c]) : '0;
      end
   end

   // ------------------------------------------------------------ ring RAM
   assign wp_in = (wp_ff == ftma_pkg::ADDR_W'(ftma_pkg::WINDOW - 1))
                ? '0 : wp_ff + 1'b1;

   // The slot being read may be the one the ring stage writes back at this
   // same edge (only with a window of one); that value is forwarded.
   assign fwd_hit = a_adv && (a_addr_ff == wp_ff);

   ftma_ram #(
      .WIDTH (ftma_pkg::CHANNELS * ftma_pkg::DATA_W),
      .DEPTH (ftma_pkg::WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (a_adv),
      .wr_addr (a_addr_ff),
      .wr_data (a_val_ff),
      .rd_en   (req_take),
      .rd_addr (wp_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         wp_ff      <= '0;
         ent_vld_ff <= '0;
      end else begin
         if (req_take) begin
            a_vld_ff <= 1'b1;
            wp_ff    <= wp_in;
         end else if (a_adv) begin
            a_vld_ff <= 1'b0;
         end
         if (a_adv) begin
            ent_vld_ff[a_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_addr_ff     <= wp_ff;
         a_val_ff      <= val_in;
         a_old_ok_ff   <= ent_vld_ff[wp_ff];
         a_fwd_ff      <= fwd_hit;
         a_fwd_data_ff <= a_val_ff;
      end
   end

   always_comb begin
      if (a_fwd_ff) begin
         old_val = a_fwd_data_ff;
      end else if (a_old_ok_ff) begin
         old_val = ram_rdata;
      end else begin
         old_val = '0;
      end
   end

   // ---------------------------------------------------------- running sum
   // The sums wrap modulo 2^SUM_W; the true window sum always fits.
   always_comb begin
      for (int c = 0; c < ftma_pkg::CHANNELS; c++) begin
         acc_in[c] = acc_ff[c]
                   + ftma_pkg::SUM_W'($signed(a_val_ff[c]))
                   - ftma_pkg::SUM_W'($signed(old_val[c]));
      end
   end

   // The sum stage holds only a flag: while it is full and blocked the ring
   // stage cannot advance, so acc_ff still holds the sums of that beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         b_vld_ff <= 1'b0;
      end else begin
         if (a_adv) begin
            acc_ff   <= acc_in;
            b_vld_ff <= 1'b1;
         end else if (b_adv) begin
            b_vld_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------ response
   // Division by WINDOW truncating toward zero: add WINDOW-1 to negative sums
   // before the shift.
   always_comb begin
      logic [ftma_pkg::SUM_W-1:0] rnd;
      for (int c = 0; c < ftma_pkg::CHANNELS; c++) begin
         rnd = acc_ff[c] + (acc_ff[c][ftma_pkg::SUM_W-1]
             ? ftma_pkg::SUM_W'(ftma_pkg::WINDOW - 1) : '0);
         mean_in[c] = rnd[ftma_pkg::WIN_SHIFT +: ftma_pkg::DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         rsp_payload_ff.avg_force_x  <= mean_in[0];
         rsp_payload_ff.avg_force_y  <= mean_in[1];
         rsp_payload_ff.avg_force_z  <= mean_in[2];
         rsp_payload_ff.avg_torque_x <= mean_in[3];
         rsp_payload_ff.avg_torque_y <= mean_in[4];
         rsp_payload_ff.avg_torque_z <= mean_in[5];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ----------------------------------------------------------- assertions
   `FTMA_ASSERT_NEXT(ring_hold_chk, clock, reset, a_vld_ff && !a_adv,
      a_vld_ff && $stable(a_addr_ff))
   `FTMA_ASSERT(wp_range_chk, clock, reset,
      wp_ff <= ftma_pkg::ADDR_W'(ftma_pkg::WINDOW - 1))
   `FTMA_ASSERT_NEXT(entry_fill_chk, clock, reset, a_adv, ent_vld_ff[$past(a_addr_ff)])
   `FTMA_ASSERT_NEXT(rsp_src_chk, clock, reset, !rsp_valid_ff && !b_vld_ff, !rsp_valid_ff)
   `FTMA_ASSERT_IMPLIES(fwd_window_chk, clock, reset, req_take && fwd_hit,
      ftma_pkg::WINDOW == 1)

endmodule

[tb/force_torque_moving_average_top_tb.sv]
`timescale 1ns / 100ps

module force_torque_moving_average_top_tb;
   import ftma_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_UNUSED = CSR_IDX_W'(7);
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   typedef enum int {RX_NONE, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_stall_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_payload;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Filter state as the block should hold it.
   logic [THR_W-1:0]         model_threshold;
   logic signed [DATA_W-1:0] model_bias [CHANNELS];
   logic signed [DATA_W-1:0] model_ring [CHANNELS][WINDOW];
   int                       model_slot;
   rsp_payload_type          pending_means [$];

   int                error_count;
   int                burst_left;
   int                gap_max;
   int                hold_request;
   rx_stall_mode_type stall_mode;

   string field_name [CHANNELS] = '{"avg_force_x", "avg_force_y", "avg_force_z",
                                    "avg_torque_x", "avg_torque_y", "avg_torque_z"};

   force_torque_moving_average_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Works out the six windowed means that one accepted sample should produce.
   task automatic predict_means(input req_payload_type s);
      logic signed [DATA_W-1:0] raw [CHANNELS];
      logic signed [DATA_W-1:0] mean [CHANNELS];
      longint                   gate_sum;
      longint                   diff;
      longint                   total;
      bit                       gate_open;
      rsp_payload_type          r;
      raw[0] = s.force_x;
      raw[1] = s.force_y;
      raw[2] = s.force_z;
      raw[3] = s.torque_x;
      raw[4] = s.torque_y;
      raw[5] = s.torque_z;
      gate_sum = 0;
      for (int c = 0; c < 3; c++) begin
         gate_sum += (raw[c] < 0) ? -longint'(raw[c]) : longint'(raw[c]);
      end
      gate_open = s.sample_valid && (gate_sum > longint'(model_threshold));
      for (int c = 0; c < CHANNELS; c++) begin
         if (gate_open) begin
            diff = longint'(raw[c]) - longint'(model_bias[c]);
            if (diff > Q_MAX) begin
               diff = Q_MAX;
            end else if (diff < Q_MIN) begin
               diff = Q_MIN;
            end
            model_ring[c][model_slot] = DATA_W'(diff);
         end else begin
            model_ring[c][model_slot] = '0;
         end
      end
      model_slot = (model_slot + 1) % WINDOW;
      for (int c = 0; c < CHANNELS; c++) begin
         total = 0;
         for (int i = 0; i < WINDOW; i++) begin
            total += longint'(model_ring[c][i]);
         end
         mean[c] = DATA_W'(total / WINDOW);
      end
      r.avg_force_x  = mean[0];
      r.avg_force_y  = mean[1];
      r.avg_force_z  = mean[2];
      r.avg_torque_x = mean[3];
      r.avg_torque_y = mean[4];
      r.avg_torque_z = mean[5];
      pending_means = {pending_means, r};
   endtask

   // Offers one sample, with a random gap at the start of each burst, and waits
   // until the block takes the beat.
   task automatic send_sample(input req_payload_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_means(s);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_GATE_THRESHOLD) begin
         model_threshold = data[THR_W-1:0];
      end else if (index <= CSR_BIAS_TORQUE_Z) begin
         model_bias[index - CSR_BIAS_FORCE_X] = data;
      end
   endtask

   task automatic program_filter(input logic [CSR_DATA_W-1:0] thr_word,
                                 input logic [CHANNELS-1:0][DATA_W-1:0] bias_words);
      write_register(CSR_GATE_THRESHOLD, thr_word);
      for (int c = 0; c < CHANNELS; c++) begin
         write_register(CSR_IDX_W'(CSR_BIAS_FORCE_X + c), bias_words[c]);
      end
      // A write past the last register must leave every setting alone.
      write_register(CSR_INDEX_UNUSED, $urandom());
   endtask

   function automatic req_payload_type make_sample(input logic valid,
                                                   input logic [DATA_W-1:0] fx,
                                                   input logic [DATA_W-1:0] fy,
                                                   input logic [DATA_W-1:0] fz,
                                                   input logic [DATA_W-1:0] tx,
                                                   input logic [DATA_W-1:0] ty,
                                                   input logic [DATA_W-1:0] tz);
      req_payload_type s;
      s.sample_valid = valid;
      s.force_x      = fx;
      s.force_y      = fy;
      s.force_z      = fz;
      s.torque_x     = tx;
      s.torque_y     = ty;
      s.torque_z     = tz;
      return s;
   endfunction

   function automatic logic [DATA_W-1:0] extreme_value();
      case ($urandom_range(0, 5))
         0: return SAT_MIN;
         1: return SAT_MAX;
         2: return '0;
         3: return '1;
         4: return DATA_W'(1);
         default: return $urandom();
      endcase
   endfunction

   // A force whose magnitude keeps the three-force sum close to the threshold.
   function automatic logic [DATA_W-1:0] near_gate_value();
      logic [DATA_W-1:0] m;
      m = $urandom_range(0, model_threshold / 2 + 2);
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   function automatic req_payload_type random_sample();
      req_payload_type   s;
      longint            boundary;
      logic [DATA_W-1:0] v;
      s = make_sample($urandom_range(0, 7) != 0, $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom());
      case ($urandom_range(0, 9))
         4, 5: begin
            s.sample_valid = 1'b1;
            s.force_x      = near_gate_value();
            s.force_y      = near_gate_value();
            s.force_z      = near_gate_value();
         end
         6: begin
            // One force sitting exactly on the threshold or one above it.
            boundary = longint'(model_threshold) + $urandom_range(0, 1);
            v = DATA_W'(boundary);
            if (boundary > Q_MAX || $urandom_range(0, 1)) begin
               v = -v;
            end
            s.sample_valid = 1'b1;
            s.force_x      = '0;
            s.force_y      = '0;
            s.force_z      = '0;
            case ($urandom_range(0, 2))
               0: s.force_x = v;
               1: s.force_y = v;
               default: s.force_z = v;
            endcase
         end
         7, 8: begin
            s = make_sample($urandom_range(0, 5) != 0, extreme_value(), extreme_value(),
                            extreme_value(), extreme_value(), extreme_value(),
                            extreme_value());
         end
         9: s.sample_valid = 1'b0;
         default: ;
      endcase
      return s;
   endfunction

   function automatic logic [DATA_W-1:0] random_bias();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return $urandom_range(0, 1) ? -DATA_W'($urandom_range(0, 1 << 18))
                                       : DATA_W'($urandom_range(0, 1 << 18));
         2: return extreme_value();
         default: return $urandom();
      endcase
   endfunction

   task automatic test_gate_and_invalid();
      // Reset settings: threshold 1.0, no bias.
      send_sample(make_sample(1'b0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
      send_sample(make_sample(1'b1, '0, '0, '0, SAT_MAX, SAT_MAX, SAT_MAX));
      send_sample(make_sample(1'b1, DATA_W'(65536), '0, '0, '1, '1, '1));
      send_sample(make_sample(1'b1, '0, -DATA_W'(65537), '0, DATA_W'(1), DATA_W'(1),
                              DATA_W'(1)));
      send_sample(make_sample(1'b1, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
      send_sample(make_sample(1'b1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
      wait_for_results();
   endtask

   task automatic test_bias_saturation();
      logic [CHANNELS-1:0][DATA_W-1:0] b;
      b[0] = SAT_MAX;
      b[1] = SAT_MIN;
      b[2] = '1;
      b[3] = DATA_W'(1);
      b[4] = SAT_MAX;
      b[5] = SAT_MIN;
      // The top bit of the threshold word lies outside the register.
      program_filter('1, b);
      send_sample(make_sample(1'b1, SAT_MIN, SAT_MAX, '0, SAT_MAX, SAT_MIN, SAT_MAX));
      send_sample(make_sample(1'b1, SAT_MAX, '0, '0, SAT_MIN, SAT_MAX, SAT_MIN));
      send_sample(make_sample(1'b1, SAT_MIN, '0, '0, SAT_MIN, SAT_MAX, SAT_MIN));
      wait_for_results();
   endtask

   task automatic test_window_extremes();
      program_filter('0, '0);
      send_sample(make_sample(1'b1, '0, '0, '0, SAT_MAX, SAT_MAX, SAT_MAX));
      send_sample(make_sample(1'b1, '0, '0, DATA_W'(1), SAT_MIN, '1, SAT_MAX));
      // A full window of the most negative value must average to itself.
      repeat (WINDOW) begin
         send_sample(make_sample(1'b1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                                 SAT_MIN));
      end
      wait_for_results();
   endtask

   task automatic test_random_phases();
      logic [CSR_DATA_W-1:0]           thr;
      logic [CHANNELS-1:0][DATA_W-1:0] b;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               thr = '0;
               b   = '0;
            end
            1: begin
               thr = '1;
               b   = {CHANNELS{SAT_MAX}};
            end
            2: begin
               thr = CSR_DATA_W'(65536);
               b   = {CHANNELS{SAT_MIN}};
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: thr = '0;
                  1: thr = CSR_DATA_W'(65536);
                  2: thr = $urandom_range(0, 1 << 20);
                  default: thr = $urandom();
               endcase
               for (int c = 0; c < CHANNELS; c++) begin
                  b[c] = random_bias();
               end
            end
         endcase
         program_filter(thr, b);
         gap_max    = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
         stall_mode = rx_stall_mode_type'(phase % 4);
         repeat (185) send_sample(random_sample());
         wait_for_results();
      end
   endtask

   task automatic test_input_backpressure();
      stall_mode = RX_NONE;
      gap_max    = 0;
      @(negedge clock);
      hold_request = 120;
      @(posedge clock);
      repeat (40) send_sample(random_sample());
      wait_for_results();
   endtask

   // Receiver pacing. A long hold-off, once requested, is counted down here.
   always @(posedge clock) begin : rx_pacing
      int hold_left;
      int pattern_count;
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      pattern_count++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            RX_RANDOM:  rsp_stall <= ($urandom_range(0, 99) < 30);
            RX_PATTERN: rsp_stall <= ((pattern_count % 11) < 4);
            RX_HEAVY:   rsp_stall <= ($urandom_range(0, 99) < 75);
            default:    rsp_stall <= 1'b0;
         endcase
      end
   end

   // Each response beat is checked against the oldest predicted set of means.
   always @(posedge clock) begin : check_means
      rsp_payload_type                 want;
      logic [CHANNELS-1:0][DATA_W-1:0] got_v;
      logic [CHANNELS-1:0][DATA_W-1:0] want_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_means.size() == 0) begin
            $error("response beat with no sample outstanding");
            error_count++;
         end else begin
            want   = pending_means.pop_front();
            got_v  = rsp_payload;
            want_v = want;
            for (int k = 0; k < CHANNELS; k++) begin
               if (got_v[CHANNELS-1-k] !== want_v[CHANNELS-1-k]) begin
                  $error("%s: expected %0d, got %0d", field_name[k],
                         $signed(want_v[CHANNELS-1-k]), $signed(got_v[CHANNELS-1-k]));
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_stall    = 1'b0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      error_count  = 0;
      burst_left   = 0;
      gap_max      = 0;
      hold_request = 0;
      stall_mode   = RX_NONE;
      model_threshold = THR_RESET;
      model_slot      = 0;
      for (int c = 0; c < CHANNELS; c++) begin
         model_bias[c] = '0;
         for (int i = 0; i < WINDOW; i++) begin
            model_ring[c][i] = '0;
         end
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_gate_and_invalid();
      test_bias_saturation();
      test_window_extremes();
      test_random_phases();
      test_input_backpressure();

      wait_for_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
